### rtl/core/hrsf_pkg.sv
// Package for the heart rate smoother framer: types, constants and codes.
// Shared by the interfaces, the front, queue and back units and the top level.
`timescale 1ns / 1ps
`default_nettype none

package hrsf_pkg;

    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 8;
    localparam int RATE_W     = 16;
    localparam int CONF_W     = 8;
    localparam int MINCONF_W  = 7;
    localparam int TIME_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam int RUN_MAX    = 3;
    localparam int RUN_IW     = 2;
    localparam int RING_DEPTH = 3;
    localparam int RING_IW    = 2;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = 1;
    localparam int Q_CW       = 2;

    localparam int SUM_W      = 10;
    localparam int PROD_W     = 20;
    // floor(s / 3) == (s * 683) >> 11 for every s up to 765
    localparam logic [SUM_W-1:0] MEAN_MUL = 10'd683;
    localparam int MEAN_SHIFT = 11;

    localparam logic [RATE_W-1:0] RATE_LOW_EXCL  = 16'd40;
    localparam logic [RATE_W-1:0] RATE_HIGH_EXCL = 16'd180;
    localparam logic [1:0]        VC_MAX         = 2'd2;

    localparam logic [STATUS_W-1:0] ST_NO_FINGER = 8'd0;
    localparam logic [STATUS_W-1:0] ST_OBJECT    = 8'd2;
    localparam logic [STATUS_W-1:0] ST_FINGER    = 8'd3;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START     = 3'd0,
        CFG_END       = 3'd1,
        CFG_SEP       = 3'd2,
        CFG_SYNC      = 3'd3,
        CFG_SYNC_IVL  = 3'd4,
        CFG_MIN_CONF  = 3'd5,
        CFG_MAX_JUMP  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_byte                  start_byte;
        t_byte                  end_byte;
        t_byte                  separator_byte;
        t_byte                  sync_byte;
        logic [TIME_W-1:0]      sync_interval_ms;
        logic [MINCONF_W-1:0]   min_confidence;
        t_byte                  max_jump;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        start_byte:       8'd2,
        end_byte:         8'd3,
        separator_byte:   8'd30,
        sync_byte:        8'd22,
        sync_interval_ms: 32'd1000,
        min_confidence:   7'd3,
        max_jump:         8'd12
    };

    typedef struct packed {
        t_byte [RUN_MAX-1:0] bytes;
        logic [RUN_IW-1:0]   cnt;
    } t_run;

    typedef struct packed {
        logic valid;
        t_run run;
    } t_push;

endpackage

`default_nettype wire

### rtl/core/hrsf_if.sv
// Handshake channels of the framer: sensor readings in, serial bytes out.
// Depends on hrsf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hrsf_in_if;
    logic                           valid;
    logic                           ready;
    logic [hrsf_pkg::STATUS_W-1:0]  sensor_status;
    logic [hrsf_pkg::RATE_W-1:0]    heart_rate;
    logic [hrsf_pkg::CONF_W-1:0]    confidence;
    logic [hrsf_pkg::TIME_W-1:0]    now_ms;

    modport source (output valid, sensor_status, heart_rate, confidence, now_ms, input ready);
    modport sink   (input valid, sensor_status, heart_rate, confidence, now_ms, output ready);
endinterface

interface hrsf_out_if;
    logic                         valid;
    logic                         ready;
    logic [hrsf_pkg::BYTE_W-1:0]  out_byte;
    logic                         last_of_run;

    modport source (output valid, out_byte, last_of_run, input ready);
    modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/core/heart_rate_smoother_framer.sv
// Heart rate smoother framer: frames sensor readings into a serial byte stream.
// The first byte of a reading is offered once it has passed the queue entry and the back unit's run register.
// Throughput: one byte per cycle on the output while o_frame.ready is high; a reading yields 0 to 3
// bytes, sent over the single output channel; up to two runs queue behind it.
// Reset (synchronous, active low) clears session, ring, queue and sets registers to defaults.
// Depends on hrsf_pkg, hrsf_if, hrsf_front, hrsf_queue and hrsf_back.
`timescale 1ns / 1ps
`default_nettype none

module heart_rate_smoother_framer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hrsf_in_if.sink                       i_sensor,
    hrsf_out_if.source                    o_frame,
    input  logic                          i_cfg_we,
    input  logic [hrsf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hrsf_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import hrsf_pkg::*;

    t_cfg   r_cfg;
    t_push  push;
    logic   q_full, head_valid, pop;
    t_run   head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START:    r_cfg.start_byte       <= i_cfg_wdata[BYTE_W-1:0];
                CFG_END:      r_cfg.end_byte         <= i_cfg_wdata[BYTE_W-1:0];
                CFG_SEP:      r_cfg.separator_byte   <= i_cfg_wdata[BYTE_W-1:0];
                CFG_SYNC:     r_cfg.sync_byte        <= i_cfg_wdata[BYTE_W-1:0];
                CFG_SYNC_IVL: r_cfg.sync_interval_ms <= i_cfg_wdata[TIME_W-1:0];
                CFG_MIN_CONF: r_cfg.min_confidence   <= i_cfg_wdata[MINCONF_W-1:0];
                CFG_MAX_JUMP: r_cfg.max_jump         <= i_cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    hrsf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sensor (i_sensor),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push)
    );

    hrsf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop        (pop),
        .o_full       (q_full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    hrsf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_frame      (o_frame)
    );

endmodule

`default_nettype wire

### rtl/core/hrsf_front.sv
// Front unit: accepts readings, updates session and smoothing state, builds byte runs.
// Depends on hrsf_pkg and hrsf_in_if.
`timescale 1ns / 1ps
`default_nettype none

module hrsf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hrsf_in_if.sink        i_sensor,
    input  hrsf_pkg::t_cfg i_cfg,
    input  logic           i_q_full,
    output hrsf_pkg::t_push o_push
);
    import hrsf_pkg::*;

    logic                      r_in_session, n_in_session;
    t_byte                     r_last_rate, n_last_rate;
    t_byte [RING_DEPTH-1:0]    r_ring, n_ring, ring_wr;
    logic [RING_IW-1:0]        r_ring_pos, n_ring_pos;
    logic [1:0]                r_valid_cnt, n_valid_cnt, vc_inc;
    logic [TIME_W-1:0]         r_sync_stamp, n_sync_stamp;

    logic                      accept, st_open, st_close, rd_ok, sync_due;
    t_byte                     rate8, mean, smooth, diff, sent;
    logic [SUM_W-1:0]          sum;
    logic [PROD_W-1:0]         prod;
    logic [TIME_W-1:0]         elapsed;
    t_run                      run;

    assign i_sensor.ready = !i_q_full;
    assign accept         = i_sensor.valid && !i_q_full;

    always_comb begin
        st_open  = (i_sensor.sensor_status == ST_OBJECT) || (i_sensor.sensor_status == ST_FINGER);
        st_close = (i_sensor.sensor_status == ST_NO_FINGER);
        rd_ok    = (i_sensor.heart_rate > RATE_LOW_EXCL) && (i_sensor.heart_rate < RATE_HIGH_EXCL)
                   && (i_sensor.confidence >= {1'b0, i_cfg.min_confidence});
        rate8    = i_sensor.heart_rate[BYTE_W-1:0];

        ring_wr             = r_ring;
        ring_wr[r_ring_pos] = rate8;
        vc_inc   = (r_valid_cnt == VC_MAX) ? r_valid_cnt : r_valid_cnt + 2'd1;

        sum      = SUM_W'(ring_wr[0]) + SUM_W'(ring_wr[1]) + SUM_W'(ring_wr[2]);
        prod     = PROD_W'(sum) * PROD_W'(MEAN_MUL);
        mean     = prod[MEAN_SHIFT+BYTE_W-1:MEAN_SHIFT];
        smooth   = (vc_inc == VC_MAX) ? mean : rate8;
        diff     = (smooth >= r_last_rate) ? smooth - r_last_rate : r_last_rate - smooth;
        sent     = (r_last_rate == '0 || diff <= i_cfg.max_jump) ? smooth : rate8;

        elapsed  = i_sensor.now_ms - r_sync_stamp;
        sync_due = elapsed > i_cfg.sync_interval_ms;

        run = '0;
        if (st_open) begin
            if (!r_in_session && rd_ok) begin
                run.bytes = {i_cfg.separator_byte, sent, i_cfg.start_byte};
                run.cnt   = 2'd3;
            end else if (!r_in_session) begin
                run.bytes[0] = i_cfg.start_byte;
                run.cnt      = 2'd1;
            end else if (rd_ok) begin
                run.bytes[0] = sent;
                run.bytes[1] = i_cfg.separator_byte;
                run.cnt      = 2'd2;
            end
        end else if (st_close) begin
            if (r_in_session && sync_due) begin
                run.bytes[0] = i_cfg.end_byte;
                run.bytes[1] = i_cfg.sync_byte;
                run.cnt      = 2'd2;
            end else if (r_in_session) begin
                run.bytes[0] = i_cfg.end_byte;
                run.cnt      = 2'd1;
            end else if (sync_due) begin
                run.bytes[0] = i_cfg.sync_byte;
                run.cnt      = 2'd1;
            end
        end

        n_in_session = r_in_session;
        n_last_rate  = r_last_rate;
        n_ring       = r_ring;
        n_ring_pos   = r_ring_pos;
        n_valid_cnt  = r_valid_cnt;
        n_sync_stamp = r_sync_stamp;
        if (accept && st_open) begin
            n_in_session = 1'b1;
            if (rd_ok) begin
                n_ring      = ring_wr;
                n_ring_pos  = (r_ring_pos == RING_IW'(RING_DEPTH - 1)) ? '0 : r_ring_pos + 2'd1;
                n_valid_cnt = vc_inc;
                n_last_rate = sent;
            end
        end else if (accept && st_close) begin
            if (r_in_session) begin
                n_in_session = 1'b0;
                n_last_rate  = '0;
                n_valid_cnt  = '0;
            end
            if (sync_due) begin
                n_sync_stamp = i_sensor.now_ms;
            end
        end
    end

    assign o_push.valid = accept && (run.cnt != '0);
    assign o_push.run   = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_session <= 1'b0;
            r_last_rate  <= '0;
            r_ring       <= '0;
            r_ring_pos   <= '0;
            r_valid_cnt  <= '0;
            r_sync_stamp <= '0;
        end else begin
            r_in_session <= n_in_session;
            r_last_rate  <= n_last_rate;
            r_ring       <= n_ring;
            r_ring_pos   <= n_ring_pos;
            r_valid_cnt  <= n_valid_cnt;
            r_sync_stamp <= n_sync_stamp;
        end
    end

endmodule

`default_nettype wire

### rtl/core/hrsf_queue.sv
// Two-entry queue of byte runs between the front and back units.
// Depends on hrsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrsf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hrsf_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_head_valid,
    output hrsf_pkg::t_run  o_head
);
    import hrsf_pkg::*;

    t_run [Q_DEPTH-1:0]  r_mem;
    logic [Q_AW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [Q_CW-1:0]     r_count, n_count;
    logic                do_pop;

    assign o_full       = (r_count == Q_CW'(Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head_valid;

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !do_pop) begin
            n_count = r_count + Q_CW'(1);
        end else if (!i_push.valid && do_pop) begin
            n_count = r_count - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/hrsf_back.sv
// Back unit: takes byte runs from the queue and sends them one beat at a time.
// Depends on hrsf_pkg and hrsf_out_if.
`timescale 1ns / 1ps
`default_nettype none

module hrsf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  hrsf_pkg::t_run i_head,
    output logic           o_pop,
    hrsf_out_if.source     o_frame
);
    import hrsf_pkg::*;

    logic               r_valid;
    t_run               r_run;
    logic [RUN_IW-1:0]  r_idx;
    logic               last, beat;

    assign last  = (RUN_IW'(r_idx + RUN_IW'(1)) == r_run.cnt);
    assign beat  = r_valid && o_frame.ready;
    assign o_pop = i_head_valid && (!r_valid || (beat && last));

    assign o_frame.valid       = r_valid;
    assign o_frame.out_byte    = r_run.bytes[r_idx];
    assign o_frame.last_of_run = last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_run <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (beat) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + RUN_IW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### sim/heart_rate_smoother_framer_tb.sv
// Self-checking testbench for heart_rate_smoother_framer: drives sensor readings,
// predicts the framed byte stream and compares it beat by beat under random stalls.
// Depends on hrsf_pkg, hrsf_if and the RTL of the framer.
`timescale 1ns / 1ps

module heart_rate_smoother_framer_tb;
    import hrsf_pkg::*;

    localparam logic [STATUS_W-1:0] ST_NOT_READY = 8'd1;
    localparam logic [STATUS_W-1:0] ST_LAST_CODE = ST_FINGER;
    localparam int BYTE_MAX       = 255;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RATE_W-1:0]   rate;
        logic [CONF_W-1:0]   conf;
        logic [TIME_W-1:0]   now;
    } t_reading;

    typedef struct packed {
        t_byte value;
        logic  last;
    } t_frame_beat;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    hrsf_in_if  sensor_bus ();
    hrsf_out_if frame_bus ();

    heart_rate_smoother_framer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sensor    (sensor_bus),
        .o_frame     (frame_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // framer state as predicted
    t_cfg              cfg_copy = CFG_RESET;
    logic              sess_open = 1'b0;
    t_byte             last_rate = '0;
    t_byte             rate_ring [RING_DEPTH] = '{default: '0};
    logic [RING_IW-1:0] ring_pos = '0;
    logic [1:0]        valid_cnt = '0;
    logic [TIME_W-1:0] sync_stamp = '0;

    t_reading    reading_q [$];
    t_frame_beat frame_q [$];
    t_reading    seen_reading;
    t_frame_beat want_beat;
    t_reading    next_reading;

    int  issued_cnt = 0;
    int  accepted_cnt = 0;
    int  err_cnt = 0;
    int  quiet_cycles = 0;
    int  in_gap = 0;
    int  out_gap = 0;
    bit  idle_on = 1'b1;
    bit  in_taken = 1'b0;
    logic [TIME_W-1:0] ms_clock = '0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic frame_reading(input t_reading rd);
        t_byte       run_bytes [$];
        logic [SUM_W-1:0] ring_sum;
        logic [RATE_W-1:0] smooth;
        logic [RATE_W-1:0] diff;
        logic [RATE_W-1:0] sent;
        t_byte       sent_b;
        logic [TIME_W-1:0] idle_ms;
        t_frame_beat fb;
        if (rd.status == ST_OBJECT || rd.status == ST_FINGER) begin
            if (!sess_open) begin
                run_bytes.push_back(cfg_copy.start_byte);
                sess_open = 1'b1;
            end
            if (rd.rate > RATE_LOW_EXCL && rd.rate < RATE_HIGH_EXCL
                    && rd.conf >= cfg_copy.min_confidence) begin
                if (valid_cnt < VC_MAX)
                    valid_cnt = valid_cnt + 1'b1;
                rate_ring[ring_pos] = rd.rate[BYTE_W-1:0];
                ring_pos = (ring_pos == RING_DEPTH - 1) ? '0 : ring_pos + 1'b1;
                if (valid_cnt == VC_MAX) begin
                    ring_sum = {2'b00, rate_ring[0]} + rate_ring[1] + rate_ring[2];
                    smooth = RATE_W'(ring_sum / RING_DEPTH);
                end else begin
                    smooth = rd.rate;
                end
                diff = (smooth >= last_rate) ? smooth - last_rate : last_rate - smooth;
                sent = (last_rate == 0 || diff <= cfg_copy.max_jump) ? smooth : rd.rate;
                sent_b = (sent > BYTE_MAX) ? t_byte'(BYTE_MAX) : sent[BYTE_W-1:0];
                last_rate = sent_b;
                run_bytes.push_back(sent_b);
                run_bytes.push_back(cfg_copy.separator_byte);
            end
        end else if (rd.status == ST_NO_FINGER) begin
            if (sess_open) begin
                run_bytes.push_back(cfg_copy.end_byte);
                sess_open = 1'b0;
                last_rate = '0;
                valid_cnt = '0;
            end
            idle_ms = rd.now - sync_stamp;
            if (idle_ms > cfg_copy.sync_interval_ms) begin
                run_bytes.push_back(cfg_copy.sync_byte);
                sync_stamp = rd.now;
            end
        end
        foreach (run_bytes[k]) begin
            fb.value = run_bytes[k];
            fb.last  = (k == run_bytes.size() - 1);
            frame_q.push_back(fb);
        end
    endtask

    task automatic push_reading(input logic [STATUS_W-1:0] status,
                                input logic [RATE_W-1:0] rate,
                                input logic [CONF_W-1:0] conf,
                                input logic [TIME_W-1:0] now);
        t_reading rd;
        rd.status = status;
        rd.rate   = rate;
        rd.conf   = conf;
        rd.now    = now;
        reading_q.push_back(rd);
        issued_cnt++;
    endtask

    task automatic drain();
        while (accepted_cnt != issued_cnt || frame_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        case (idx)
            CFG_START:    cfg_copy.start_byte       = value[BYTE_W-1:0];
            CFG_END:      cfg_copy.end_byte         = value[BYTE_W-1:0];
            CFG_SEP:      cfg_copy.separator_byte   = value[BYTE_W-1:0];
            CFG_SYNC:     cfg_copy.sync_byte        = value[BYTE_W-1:0];
            CFG_SYNC_IVL: cfg_copy.sync_interval_ms = value[TIME_W-1:0];
            CFG_MIN_CONF: cfg_copy.min_confidence   = value[MINCONF_W-1:0];
            CFG_MAX_JUMP: cfg_copy.max_jump         = value[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input t_byte start_b, input t_byte end_b,
                                  input t_byte sep_b, input t_byte sync_b,
                                  input logic [TIME_W-1:0] ivl,
                                  input logic [MINCONF_W-1:0] min_conf,
                                  input t_byte max_jump);
        drain();
        write_reg(CFG_START, CFG_DATA_W'(start_b));
        write_reg(CFG_END, CFG_DATA_W'(end_b));
        write_reg(CFG_SEP, CFG_DATA_W'(sep_b));
        write_reg(CFG_SYNC, CFG_DATA_W'(sync_b));
        write_reg(CFG_SYNC_IVL, CFG_DATA_W'(ivl));
        write_reg(CFG_MIN_CONF, CFG_DATA_W'(min_conf));
        write_reg(CFG_MAX_JUMP, CFG_DATA_W'(max_jump));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // sessions of mostly well-formed readings around a base rate, with noise mixed in
    task automatic add_sessions(input int n);
        int left;
        int sess_len;
        int base;
        int r;
        int pick;
        logic [STATUS_W-1:0] st;
        logic [RATE_W-1:0]   rate;
        logic [CONF_W-1:0]   conf;
        logic [TIME_W-1:0]   now;
        left = n;
        while (left > 0) begin
            sess_len = $urandom_range(1, 8);
            base = $urandom_range(45, 175);
            for (int k = 0; k < sess_len && left > 0; k++) begin
                pick = $urandom_range(0, 9);
                ms_clock = ms_clock + $urandom_range(0, 700);
                now = ($urandom_range(0, 19) == 0) ? $urandom : ms_clock;
                st = $urandom_range(0, 1) ? ST_FINGER : ST_OBJECT;
                if (pick < 7) begin
                    r = base + $urandom_range(0, 30) - 15;
                    if (r < 41) r = 41;
                    if (r > 179) r = 179;
                    rate = RATE_W'(r);
                    conf = CONF_W'($urandom_range(cfg_copy.min_confidence, BYTE_MAX));
                end else if (pick == 7) begin
                    rate = RATE_W'($urandom);
                    conf = CONF_W'($urandom);
                end else if (pick == 8) begin
                    st = $urandom_range(0, 1) ? ST_NOT_READY
                                              : STATUS_W'($urandom_range(ST_LAST_CODE + 1,
                                                                         BYTE_MAX));
                    rate = RATE_W'($urandom);
                    conf = CONF_W'($urandom);
                end else begin
                    st = STATUS_W'($urandom_range(0, BYTE_MAX));
                    rate = RATE_W'($urandom);
                    conf = CONF_W'($urandom);
                end
                push_reading(st, rate, conf, now);
                left--;
            end
            if (left > 0 && $urandom_range(0, 19) < 17) begin
                ms_clock = ms_clock + $urandom_range(0, 1200);
                push_reading(ST_NO_FINGER, RATE_W'($urandom), CONF_W'($urandom), ms_clock);
                left--;
            end
        end
    endtask

    task automatic random_settings();
        apply_settings(t_byte'($urandom_range(0, BYTE_MAX)), t_byte'($urandom_range(0, BYTE_MAX)),
                       t_byte'($urandom_range(0, BYTE_MAX)), t_byte'($urandom_range(0, BYTE_MAX)),
                       TIME_W'($urandom_range(0, 1500)), MINCONF_W'($urandom_range(0, 20)),
                       t_byte'($urandom_range(0, 40)));
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            sensor_bus.valid <= 1'b0;
        end else if (!sensor_bus.valid || in_taken) begin
            in_taken = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                sensor_bus.valid <= 1'b0;
            end else if (reading_q.size() > 0) begin
                next_reading = reading_q.pop_front();
                sensor_bus.sensor_status <= next_reading.status;
                sensor_bus.heart_rate    <= next_reading.rate;
                sensor_bus.confidence    <= next_reading.conf;
                sensor_bus.now_ms        <= next_reading.now;
                sensor_bus.valid         <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    in_gap = $urandom_range(1, 6);
            end else begin
                sensor_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            frame_bus.ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            frame_bus.ready <= 1'b0;
        end else begin
            frame_bus.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 4) == 0)
                out_gap = $urandom_range(1, 6);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && sensor_bus.valid && sensor_bus.ready) begin
            seen_reading.status = sensor_bus.sensor_status;
            seen_reading.rate   = sensor_bus.heart_rate;
            seen_reading.conf   = sensor_bus.confidence;
            seen_reading.now    = sensor_bus.now_ms;
            frame_reading(seen_reading);
            accepted_cnt++;
            in_taken = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && frame_bus.valid && frame_bus.ready) begin
            if (frame_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected beat: byte %0d last %0b",
                             frame_bus.out_byte, frame_bus.last_of_run);
            end else begin
                want_beat = frame_q.pop_front();
                if (frame_bus.out_byte !== want_beat.value
                        || frame_bus.last_of_run !== want_beat.last) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("beat mismatch: byte exp %0d got %0d, last exp %0b got %0b",
                                 want_beat.value, frame_bus.out_byte,
                                 want_beat.last, frame_bus.last_of_run);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((sensor_bus.valid && sensor_bus.ready) || (frame_bus.valid && frame_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("heart_rate_smoother_framer_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        sensor_bus.valid = 1'b0;
        sensor_bus.sensor_status = '0;
        sensor_bus.heart_rate = '0;
        sensor_bus.confidence = '0;
        sensor_bus.now_ms = '0;
        frame_bus.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: sync timing, bounds of rate and confidence, jump handling
        push_reading(ST_NO_FINGER, 16'd0, 8'd0, 32'd500);
        push_reading(ST_NO_FINGER, 16'd0, 8'd0, 32'd1001);
        push_reading(ST_NOT_READY, 16'd100, 8'd100, 32'd1100);
        push_reading(8'd255, 16'd100, 8'd100, 32'd1100);
        push_reading(ST_FINGER, 16'd41, 8'd3, 32'd1200);
        push_reading(ST_FINGER, 16'd179, 8'd255, 32'd1300);
        push_reading(ST_OBJECT, 16'd40, 8'd100, 32'd1400);
        push_reading(ST_OBJECT, 16'd180, 8'd100, 32'd1400);
        push_reading(ST_FINGER, 16'd100, 8'd2, 32'd1400);
        push_reading(ST_FINGER, 16'd0, 8'd0, 32'd1400);
        push_reading(ST_FINGER, 16'hFFFF, 8'd255, 32'd1400);
        push_reading(ST_FINGER, 16'd120, 8'd50, 32'd1450);
        push_reading(ST_FINGER, 16'd120, 8'd50, 32'd1460);
        push_reading(ST_OBJECT, 16'd120, 8'd50, 32'd1470);
        push_reading(ST_OBJECT, 16'd125, 8'd50, 32'd1480);
        push_reading(8'd4, 16'd120, 8'd50, 32'd1490);
        push_reading(ST_NO_FINGER, 16'd120, 8'd50, 32'd1500);
        push_reading(ST_OBJECT, 16'd60, 8'd99, 32'd1600);
        push_reading(ST_NO_FINGER, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        push_reading(ST_NO_FINGER, 16'd0, 8'd0, 32'h0000_03E7);
        push_reading(ST_NO_FINGER, 16'd0, 8'd0, 32'h0000_03E8);
        push_reading(ST_OBJECT, 16'd0, 8'd0, 32'h0000_0400);
        push_reading(ST_FINGER, 16'd90, 8'd3, 32'h0000_0410);
        push_reading(ST_FINGER, 16'd100, 8'd3, 32'h0000_0420);
        ms_clock = 32'h0000_0500;

        apply_settings(8'd0, 8'd255, 8'd0, 8'd255, 32'd0, 7'd0, 8'd0);
        add_sessions(16);

        apply_settings(8'd255, 8'd0, 8'd255, 8'd0, 32'hFFFF_FFFF, 7'd100, 8'd255);
        add_sessions(16);

        random_settings();
        add_sessions(18);

        random_settings();
        add_sessions(18);

        random_settings();
        idle_on = 1'b0;
        add_sessions(18);

        drain();
        if (err_cnt == 0 && frame_q.size() == 0) begin
            $display("heart_rate_smoother_framer_tb OK");
        end else begin
            $display("heart_rate_smoother_framer_tb NOT OK");
        end
        $finish;
    end

endmodule
